// ===== hdl/prqs_pkg.sv =====
// Package: shared types and constants of the pulsed relay queue sequencer.
`default_nettype none
package prqs_pkg;
	localparam int RELAY_W   = 8;
	localparam int MS_W      = 16;
	localparam int SLOT_W    = 4;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_INSERTED = 2'd1,
		ST_QUEUED   = 2'd2,
		ST_FULL     = 2'd3
	} add_status_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_ON       = 2'd1,
		PH_RECHARGE = 2'd2
	} phase_t;

	localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECHARGE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd2;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ADD  = 1'b1;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SRCH_RD  = 7'b0000010,
		S_SRCH_CMP = 7'b0000100,
		S_INSERT   = 7'b0001000,
		S_HEAD_RD  = 7'b0010000,
		S_STEP     = 7'b0100000,
		S_EMIT     = 7'b1000000
	} state_t;

	typedef struct packed {
		logic accept;
		logic srch_rd;
		logic srch_cmp;
		logic insert;
		logic head_rd;
		logic step;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_add;
		logic srch_end;
		logic match;
		logic out_free;
	} ctl_sts_t;
endpackage
`default_nettype wire

// ===== hdl/prqs_if.sv =====
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface prqs_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] relay_number;
	modport source (output valid, output cmd, output relay_number, input ready);
	modport sink (input valid, input cmd, input relay_number, output ready);
endinterface

interface prqs_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] add_status;
	logic [3:0] slot_index;
	logic       drive_valid;
	logic [7:0] drive_relay;
	logic       drive_command_on;
	logic [1:0] phase;
	modport source (output valid, output add_status, output slot_index, output drive_valid,
		output drive_relay, output drive_command_on, output phase, input ready);
	modport sink (input valid, input add_status, input slot_index, input drive_valid,
		input drive_relay, input drive_command_on, input phase, output ready);
endinterface

interface prqs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pulsed_relay_queue_sequencer_top.sv =====
// Sequence: a tick item passes head read, step and emit states into the output register;
// an add item first reads and compares each entry examined, then inserts if not found.
// Throughput: one item at a time; the next item is accepted the cycle after the result
// enters the output register, so a stalled result still lets one more item start.
// Reset: arst_n clears the queue to empty, the sequencer to idle, times to 0 and
// active_high to 1; the queue memory itself is not cleared.
`default_nettype none
module pulsed_relay_queue_sequencer_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	prqs_in_if.sink     item_in,
	prqs_out_if.source  item_out,
	prqs_cfg_if.sink    cfg
);
	import prqs_pkg::*;

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	prqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (item_in.ready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	prqs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (ctl_cmd),
		.sts                  (ctl_sts),
		.in_cmd               (item_in.cmd),
		.in_relay             (item_in.relay_number),
		.cfg_valid            (cfg.valid),
		.cfg_ready            (cfg.ready),
		.cfg_index            (cfg.index),
		.cfg_data             (cfg.data),
		.out_valid            (item_out.valid),
		.out_ready            (item_out.ready),
		.out_add_status       (item_out.add_status),
		.out_slot_index       (item_out.slot_index),
		.out_drive_valid      (item_out.drive_valid),
		.out_drive_relay      (item_out.drive_relay),
		.out_drive_command_on (item_out.drive_command_on),
		.out_phase            (item_out.phase)
	);

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && (item_out.add_status == ST_NONE || item_out.add_status == ST_FULL)
		|-> item_out.slot_index == '0)
		else $error("slot index set without a placed relay");

	a_drive_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && !item_out.drive_valid
		|-> item_out.drive_relay == '0 && !item_out.drive_command_on)
		else $error("drive fields set without a drive");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.emit |-> ctl_sts.out_free)
		else $error("result overwrites a pending item");
endmodule
`default_nettype wire

// ===== hdl/prqs_ctrl.sv =====
// Controller: one-hot state machine sequencing search, insert and sequencer step.
`default_nettype none
module prqs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  prqs_pkg::ctl_sts_t sts,
	output prqs_pkg::ctl_cmd_t cmd
);
	import prqs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.is_add ? S_SRCH_RD : S_HEAD_RD;
				end
			end
			S_SRCH_RD: begin
				cmd.srch_rd = 1'b1;
				state_d     = sts.srch_end ? S_INSERT : S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
				state_d      = sts.match ? S_HEAD_RD : S_SRCH_RD;
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_HEAD_RD;
			end
			S_HEAD_RD: begin
				cmd.head_rd = 1'b1;
				state_d     = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/prqs_dp.sv =====
// Datapath: circular queue memory, timers, configuration and result registers.
`default_nettype none
module prqs_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  prqs_pkg::ctl_cmd_t                   cmd,
	output prqs_pkg::ctl_sts_t                   sts,
	input  logic                                 in_cmd,
	input  logic [prqs_pkg::RELAY_W-1:0]         in_relay,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [prqs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [prqs_pkg::MS_W-1:0]            cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           out_add_status,
	output logic [prqs_pkg::SLOT_W-1:0]          out_slot_index,
	output logic                                 out_drive_valid,
	output logic [prqs_pkg::RELAY_W-1:0]         out_drive_relay,
	output logic                                 out_drive_command_on,
	output logic [1:0]                           out_phase
);
	import prqs_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W:0]   DEPTH_W = (IDX_W + 1)'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(QUEUE_DEPTH - 1);

	logic [RELAY_W-1:0] mem_q [QUEUE_DEPTH];
	logic [RELAY_W-1:0] rd_data_q;

	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [MS_W-1:0]    rem_q;
	phase_t             phase_q;
	logic [MS_W-1:0]    on_time_q;
	logic [MS_W-1:0]    recharge_q;
	logic               act_high_q;

	logic [RELAY_W-1:0] relay_q;
	add_status_t        status_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               dvalid_q;
	logic [RELAY_W-1:0] drelay_q;
	logic               don_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_dvalid_q;
	logic [RELAY_W-1:0] out_drelay_q;
	logic               out_don_q;
	logic [1:0]         out_phase_q;

	logic [CNT_W-1:0]   rd_off;
	logic [IDX_W:0]     rd_sum;
	logic [IDX_W:0]     wr_sum;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   head_next;

	assign rd_off  = cmd.srch_rd ? idx_q : '0;
	assign rd_sum  = {1'b0, head_q} + (IDX_W + 1)'(rd_off);
	assign wr_sum  = {1'b0, head_q} + (IDX_W + 1)'(count_q);
	assign rd_addr = (rd_sum >= DEPTH_W) ? IDX_W'(rd_sum - DEPTH_W) : IDX_W'(rd_sum);
	assign wr_addr = (wr_sum >= DEPTH_W) ? IDX_W'(wr_sum - DEPTH_W) : IDX_W'(wr_sum);
	assign head_next = (head_q == LAST_IX) ? '0 : head_q + 1'b1;

	// queue memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.insert && count_q != DEPTH_C) begin
			mem_q[wr_addr] <= relay_q;
		end
		if (cmd.srch_rd || cmd.head_rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign sts.is_add   = (in_cmd == CMD_ADD);
	assign sts.srch_end = (idx_q == count_q);
	assign sts.match    = (rd_data_q == relay_q);
	assign sts.out_free = !out_valid_q || out_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q  <= '0;
			recharge_q <= '0;
			act_high_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ON_TIME:     on_time_q  <= cfg_data;
				CFG_RECHARGE:    recharge_q <= cfg_data;
				CFG_ACTIVE_HIGH: act_high_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// item payload and per-item results
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			relay_q  <= in_relay;
			status_q <= ST_NONE;
			slot_q   <= '0;
			idx_q    <= '0;
		end
		if (cmd.srch_cmp) begin
			if (sts.match) begin
				status_q <= ST_QUEUED;
				slot_q   <= SLOT_W'(idx_q);
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (cmd.insert) begin
			if (count_q == DEPTH_C) begin
				status_q <= ST_FULL;
				slot_q   <= '0;
			end else begin
				status_q <= ST_INSERTED;
				slot_q   <= SLOT_W'(count_q);
			end
		end
		if (cmd.step) begin
			dvalid_q <= 1'b0;
			drelay_q <= '0;
			don_q    <= 1'b0;
			unique case (phase_q)
				PH_ON: begin
					if (rem_q == '0) begin
						dvalid_q <= 1'b1;
						drelay_q <= rd_data_q;
						don_q    <= !act_high_q;
					end
				end
				default: begin
					if ((phase_q != PH_RECHARGE || rem_q == '0) && count_q != '0) begin
						dvalid_q <= 1'b1;
						drelay_q <= rd_data_q;
						don_q    <= act_high_q;
					end
				end
			endcase
		end
	end

	// queue pointers, timer and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rem_q   <= '0;
			phase_q <= PH_IDLE;
		end else begin
			if (cmd.accept && in_cmd == CMD_TICK && rem_q != '0) begin
				rem_q <= rem_q - 1'b1;
			end
			if (cmd.insert && !sts.srch_end) begin
				count_q <= count_q;
			end else if (cmd.insert && count_q != DEPTH_C) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.step) begin
				unique case (phase_q)
					PH_ON: begin
						if (rem_q == '0) begin
							rem_q   <= recharge_q;
							head_q  <= head_next;
							phase_q <= PH_RECHARGE;
							if (count_q != '0) begin
								count_q <= count_q - 1'b1;
							end
						end
					end
					PH_RECHARGE: begin
						if (rem_q == '0) begin
							if (count_q != '0) begin
								rem_q   <= on_time_q;
								phase_q <= PH_ON;
							end else begin
								phase_q <= PH_IDLE;
							end
						end
					end
					default: begin
						phase_q <= PH_IDLE;
						if (count_q != '0) begin
							rem_q   <= on_time_q;
							phase_q <= PH_ON;
						end
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= status_q;
			out_slot_q   <= slot_q;
			out_dvalid_q <= dvalid_q;
			out_drelay_q <= drelay_q;
			out_don_q    <= don_q;
			out_phase_q  <= phase_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign out_add_status       = out_status_q;
	assign out_slot_index       = out_slot_q;
	assign out_drive_valid      = out_dvalid_q;
	assign out_drive_relay      = out_drelay_q;
	assign out_drive_command_on = out_don_q;
	assign out_phase            = out_phase_q;
endmodule
`default_nettype wire

// ===== tb/sv/pulsed_relay_queue_sequencer_top_tb.sv =====
// Testbench: random and directed items against a scoreboard predicting the relay queue sequencer.
`timescale 1ns / 100ps
module pulsed_relay_queue_sequencer_top_tb;
	import prqs_pkg::*;

	localparam int QDEPTH = 16;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int MAX_REPORTS = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		add_status_t         status;
		logic [SLOT_W-1:0]   slot;
		logic                drive;
		logic [RELAY_W-1:0]  relay;
		logic                cmd_on;
		phase_t              ph;
	} relay_result_t;

	class relay_scoreboard;
		logic [RELAY_W-1:0] slots[QDEPTH];
		int unsigned        fill;
		phase_t             ph;
		logic [MS_W-1:0]    left_ms;
		logic [MS_W-1:0]    on_ms;
		logic [MS_W-1:0]    rest_ms;
		logic               energize_on;
		relay_result_t      awaited[$];
		int                 mismatches;
		int                 items;
		int                 checked;
		int                 n_inserted;
		int                 n_queued;
		int                 n_full;
		int                 n_drives;

		function new();
			foreach (slots[i])
				slots[i] = 8'hFF;
			fill = 0;
			ph = PH_IDLE;
			left_ms = '0;
			on_ms = '0;
			rest_ms = '0;
			energize_on = 1'b1;
			mismatches = 0;
			items = 0;
			checked = 0;
			n_inserted = 0;
			n_queued = 0;
			n_full = 0;
			n_drives = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				CFG_ON_TIME: on_ms = data;
				CFG_RECHARGE: rest_ms = data;
				CFG_ACTIVE_HIGH: energize_on = data[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_item(logic cmd, logic [RELAY_W-1:0] relay);
			relay_result_t r;
			bit hit;
			r = '0;
			r.status = ST_NONE;
			hit = 0;
			items++;
			if (cmd == CMD_TICK) begin
				if (left_ms != 0)
					left_ms--;
			end else begin
				for (int i = 0; i < fill; i++) begin
					if (!hit && slots[i] == relay) begin
						hit = 1;
						r.status = ST_QUEUED;
						r.slot = i[SLOT_W-1:0];
					end
				end
				if (!hit) begin
					if (fill < QDEPTH) begin
						slots[fill] = relay;
						r.status = ST_INSERTED;
						r.slot = fill[SLOT_W-1:0];
						fill++;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			case (ph)
				PH_ON: begin
					if (left_ms == 0) begin
						r.drive = 1'b1;
						r.relay = slots[0];
						r.cmd_on = !energize_on;
						left_ms = rest_ms;
						for (int i = 0; i < QDEPTH - 1; i++)
							slots[i] = slots[i+1];
						slots[QDEPTH-1] = 8'hFF;
						if (fill > 0)
							fill--;
						ph = PH_RECHARGE;
					end
				end
				PH_RECHARGE: begin
					if (left_ms == 0) begin
						if (fill > 0) begin
							r.drive = 1'b1;
							r.relay = slots[0];
							r.cmd_on = energize_on;
							left_ms = on_ms;
							ph = PH_ON;
						end else begin
							ph = PH_IDLE;
						end
					end
				end
				default: begin
					ph = PH_IDLE;
					if (fill > 0) begin
						r.drive = 1'b1;
						r.relay = slots[0];
						r.cmd_on = energize_on;
						left_ms = on_ms;
						ph = PH_ON;
					end
				end
			endcase
			r.ph = ph;
			awaited.push_back(r);
		endfunction

		function void check_result(relay_result_t got);
			relay_result_t exp;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result with nothing awaited: status %0d slot %0d drive %0d",
						got.status, got.slot, got.drive);
				return;
			end
			exp = awaited.pop_front();
			checked++;
			case (exp.status)
				ST_INSERTED: n_inserted++;
				ST_QUEUED: n_queued++;
				ST_FULL: n_full++;
				default: ;
			endcase
			if (exp.drive)
				n_drives++;
			if (got.status != exp.status || got.slot != exp.slot || got.drive != exp.drive ||
				got.relay != exp.relay || got.cmd_on != exp.cmd_on || got.ph != exp.ph) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$write("mismatch on result %0d: expected st %0d slot %0d drv %0d",
						checked, exp.status, exp.slot, exp.drive);
					$write(" relay %0d on %0d ph %0d,", exp.relay, exp.cmd_on, exp.ph);
					$display(" got st %0d slot %0d drv %0d relay %0d on %0d ph %0d",
						got.status, got.slot, got.drive, got.relay, got.cmd_on, got.ph);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	prqs_in_if  item_if();
	prqs_out_if res_if();
	prqs_cfg_if cfg_if();

	pulsed_relay_queue_sequencer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_if),
		.item_out (res_if),
		.cfg      (cfg_if)
	);

	relay_scoreboard sb;
	int src_calm;
	int snk_calm;
	int cfg_writes;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	task automatic send_item(logic cmd, logic [RELAY_W-1:0] relay);
		int gap;
		gap = draw_wait(src_calm);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.cmd <= cmd;
		item_if.relay_number <= relay;
		do @(posedge clk); while (!item_if.ready);
		sb.note_item(cmd, relay);
	endtask

	task automatic send_random(int add_pct);
		logic cmd;
		logic [RELAY_W-1:0] relay;
		int pick;
		cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_TICK;
		pick = $urandom_range(0, 9);
		if (cmd == CMD_TICK || pick >= 8)
			relay = 8'($urandom_range(0, 255));
		else if (pick == 7)
			relay = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'd254;
		else
			relay = 8'($urandom_range(0, 23));
		send_item(cmd, relay);
	endtask

	// lower valid at the current edge and wait for all results to come back
	task automatic drain();
		item_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, data);
		cfg_writes++;
	endtask

	task automatic program_times(logic [15:0] on_ms, logic [15:0] rest_ms, logic [15:0] ah);
		cfg_write(CFG_ON_TIME, on_ms);
		cfg_write(CFG_RECHARGE, rest_ms);
		cfg_write(CFG_ACTIVE_HIGH, ah);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		relay_result_t got;
		res_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			int stall;
			stall = draw_wait(snk_calm);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			got.status = add_status_t'(res_if.add_status);
			got.slot = res_if.slot_index;
			got.drive = res_if.drive_valid;
			got.relay = res_if.drive_relay;
			got.cmd_on = res_if.drive_command_on;
			got.ph = phase_t'(res_if.phase);
			sb.check_result(got);
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles", LIMIT_CYCLES);
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [15:0] on_set[6];
		logic [15:0] rest_set[6];
		logic ah_set[6];
		int add_pct;
		sb = new();
		src_calm = 0;
		snk_calm = 0;
		cfg_writes = 0;
		arst_n <= 1'b0;
		item_if.valid <= 1'b0;
		item_if.cmd <= CMD_TICK;
		item_if.relay_number <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_ON_TIME;
		cfg_if.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero times: each delay ends at the next item, relay 255 is an ordinary number
		send_item(CMD_ADD, 8'd0);
		send_item(CMD_ADD, 8'd255);
		send_item(CMD_ADD, 8'd255);
		repeat (3) send_item(CMD_TICK, 8'd255);
		drain();

		// adds do not advance time, so the queue fills behind the first pulse
		program_times(16'd1, 16'd0, 16'hFFFE);
		for (int n = 1; n <= 17; n++)
			send_item(CMD_ADD, n[7:0]);
		send_item(CMD_ADD, 8'd8);
		send_item(CMD_ADD, 8'd1);
		send_item(CMD_TICK, 8'd0);
		drain();

		cfg_write(CFG_UNUSED, 16'($urandom));
		cfg_if.valid <= 1'b0;

		on_set = '{16'd0, 16'd2, 16'd0, 16'd4, 16'($urandom_range(0, 6)), 16'd1};
		rest_set = '{16'd0, 16'd1, 16'd3, 16'd0, 16'($urandom_range(0, 6)), 16'd1};
		ah_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b0};
		for (int p = 0; p < 6; p++) begin
			@(posedge clk);
			program_times(on_set[p], rest_set[p], {15'($urandom), ah_set[p]});
			add_pct = $urandom_range(15, 60);
			repeat (205) send_random(add_pct);
			drain();
		end

		// widest delays last: the sequencer cannot leave them within the run
		@(posedge clk);
		program_times(16'd2, 16'hFFFF, 16'h0001);
		repeat (30) send_random(50);
		drain();
		@(posedge clk);
		program_times(16'hFFFF, 16'hFFFF, 16'h0000);
		repeat (20) send_random(50);
		drain();
		repeat (12) @(posedge clk);

		$display("run: %0d items, %0d results checked, %0d register writes",
			sb.items, sb.checked, cfg_writes);
		$display("run: %0d inserted, %0d already queued, %0d full, %0d relay drives",
			sb.n_inserted, sb.n_queued, sb.n_full, sb.n_drives);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
			$display("status: fail");
		end
		$finish;
	end
endmodule
